// ----- design/mde_pkg.sv -----
// Shared types, codes and constant tables of the main domain extractor.
// No dependencies; mde_ip_parse and main_domain_extractor import this package.
`default_nettype none

package mde_pkg;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    // Result kinds.
    localparam logic [1:0] KIND_MAIN    = 2'd0;
    localparam logic [1:0] KIND_IPV4    = 2'd1;
    localparam logic [1:0] KIND_NO_DOT  = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // Register index of the output limit.
    localparam logic REG_OUT_LIMIT = 1'b0;
    localparam logic [8:0] OUT_LIMIT_RESET = 9'd255;

    // Part values saturate one above the largest 32-bit value.
    localparam logic [32:0] IP_SAT = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_HEX0,
        PH_OCT,
        PH_DEC,
        PH_HEX,
        PH_TAIL,
        PH_FAIL
    } t_ip_phase;

    typedef struct packed {
        t_ip_phase   phase;
        logic [1:0]  parts;
        logic [32:0] value;
    } t_ip_state;

    typedef struct packed {
        logic [7:0] start_res;
        logic [7:0] length;
        logic [1:0] kind;
        logic       too_long;
    } t_result;

    localparam int IGN2_N = 41;
    localparam int IGN3_N = 6;

    localparam logic [15:0] IGN2 [IGN2_N] = '{
        "ac", "ah", "bj", "co", "cq", "ed", "fj", "gd", "go", "gs", "gx",
        "gz", "ha", "hb", "he", "hi", "hk", "hl", "hn", "jl", "js", "jx",
        "ln", "mo", "ne", "nm", "nx", "or", "pe", "qh", "sc", "sd", "sh",
        "sn", "sx", "tj", "tw", "xj", "xz", "yn", "zj"
    };

    localparam logic [23:0] IGN3 [IGN3_N] = '{
        "com", "edu", "gov", "net", "org", "www"
    };

    // Exact, case sensitive match of the last label against the ignore list.
    function automatic logic label_ignored(input logic [23:0] window,
                                           input logic [2:0]  count);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < IGN2_N; i++) begin
            if (count == 3'd2 && window[15:0] == IGN2[i]) begin
                hit = 1'b1;
            end
        end
        for (int i = 0; i < IGN3_N; i++) begin
            if (count == 3'd3 && window == IGN3[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- design/mde_in_if.sv -----
// Input channel of the main domain extractor: one name byte per request.
// Standalone; no package dependency.
`default_nettype none

interface mde_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// ----- design/mde_out_if.sv -----
// Result channel of the main domain extractor: one result per name.
// Standalone; no package dependency.
`default_nettype none

interface mde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] start_res;
    logic [7:0] length;
    logic [1:0] kind;
    logic       too_long;

    modport source (output valid, output start_res, output length, output kind,
                    output too_long, input ready);
    modport sink   (input valid, input start_res, input length, input kind,
                    input too_long, output ready);
endinterface

`default_nettype wire

// ----- design/mde_ip_parse.sv -----
// One byte step of the classic numeric IPv4 address parser (dotted decimal,
// octal and hex parts), plus the validity check of the resulting state.
// Depends on mde_pkg.
`default_nettype none

module mde_ip_parse
    import mde_pkg::*;
(
    input  wire t_ip_state  i_state,
    input  wire logic [7:0] i_ch,
    output t_ip_state       o_state,
    output logic            o_valid
);

    logic        is_dec;
    logic        is_oct;
    logic        is_hex;
    logic [3:0]  hex_d;
    logic        delim;
    logic        acc_en;
    logic [36:0] acc_wide;
    logic [32:0] acc_val;
    logic [32:0] part_max;

    always_comb begin
        is_dec = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        is_oct = (i_ch >= CH_ZERO) && (i_ch <= CH_SEVEN);
        is_hex = 1'b1;
        hex_d  = 4'd0;
        if (is_dec) begin
            hex_d = i_ch[3:0];
        end else if (i_ch >= 8'h61 && i_ch <= 8'h66) begin
            hex_d = 4'(i_ch - 8'h57);
        end else if (i_ch >= 8'h41 && i_ch <= 8'h46) begin
            hex_d = 4'(i_ch - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Digit accumulation by shifts and adds; the value saturates so that any
    // out-of-range part stays out of range.
    always_comb begin
        case (i_state.phase)
            PH_OCT:  acc_wide = {1'b0, i_state.value, 3'b000} + 37'(hex_d);
            PH_HEX:  acc_wide = {i_state.value, 4'b0000} + 37'(hex_d);
            default: acc_wide = {1'b0, i_state.value, 3'b000}
                                + {3'b000, i_state.value, 1'b0}
                                + 37'(hex_d);
        endcase
        acc_val = (acc_wide > 37'(IP_SAT)) ? IP_SAT : acc_wide[32:0];
    end

    always_comb begin
        o_state = i_state;
        delim   = 1'b0;
        acc_en  = 1'b0;
        case (i_state.phase)
            PH_START: begin
                if (i_ch == CH_ZERO) begin
                    o_state.value = '0;
                    o_state.phase = PH_ZERO;
                end else if (is_dec) begin
                    o_state.value = 33'(i_ch[3:0]);
                    o_state.phase = PH_DEC;
                end else begin
                    o_state.phase = PH_FAIL;
                end
            end
            PH_ZERO: begin
                if (i_ch == CH_X_LO || i_ch == CH_X_UP) begin
                    o_state.phase = PH_HEX0;
                end else if (is_oct) begin
                    o_state.value = 33'(i_ch[2:0]);
                    o_state.phase = PH_OCT;
                end else begin
                    delim = 1'b1;
                end
            end
            PH_HEX0: begin
                if (is_hex) begin
                    o_state.value = 33'(hex_d);
                    o_state.phase = PH_HEX;
                end else begin
                    o_state.phase = PH_FAIL;
                end
            end
            PH_OCT: begin
                if (is_oct) acc_en = 1'b1;
                else delim = 1'b1;
            end
            PH_DEC: begin
                if (is_dec) acc_en = 1'b1;
                else delim = 1'b1;
            end
            PH_HEX: begin
                if (is_hex) acc_en = 1'b1;
                else delim = 1'b1;
            end
            default: begin
            end
        endcase
        if (acc_en) begin
            o_state.value = acc_val;
        end
        if (delim) begin
            if (i_ch == CH_DOT) begin
                if (i_state.parts == 2'd3 || i_state.value > 33'd255) begin
                    o_state.phase = PH_FAIL;
                end else begin
                    o_state.parts = i_state.parts + 2'd1;
                    o_state.value = '0;
                    o_state.phase = PH_START;
                end
            end else if (i_ch == CH_SPACE || (i_ch >= CH_TAB && i_ch <= CH_CR)) begin
                o_state.phase = PH_TAIL;
            end else begin
                o_state.phase = PH_FAIL;
            end
        end
    end

    always_comb begin
        case (o_state.parts)
            2'd0:    part_max = 33'hFFFF_FFFF;
            2'd1:    part_max = 33'h00FF_FFFF;
            2'd2:    part_max = 33'h0000_FFFF;
            default: part_max = 33'h0000_00FF;
        endcase
        o_valid = !(o_state.phase == PH_START || o_state.phase == PH_HEX0 ||
                    o_state.phase == PH_FAIL) && (o_state.value <= part_max);
    end

endmodule

`default_nettype wire

// ----- design/main_domain_extractor.sv -----
// Main domain extractor. Host name bytes arrive one per request, the final
// byte flagged by last; when that byte is taken the result (start, length,
// kind, overflow flag) is registered and presented on the result channel.
// The block takes one byte every cycle unless input is refused: all per-byte
// state updates, the label match against the ignore list and the IPv4 parse
// step are combinational between the state and result registers. The result
// side has an output register backed by one hold register, so input is refused
// only while two results wait. The output limit register sits at address 0.
// Depends on mde_pkg, mde_in_if, mde_out_if and mde_ip_parse.
`default_nettype none

module main_domain_extractor
    import mde_pkg::*;
#(
    parameter int MAX_LEN = 255
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mde_in_if.sink           i_req,
    mde_out_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [8:0]  r_out_limit;
    logic [7:0]  r_pos,      n_pos;
    logic [8:0]  r_final,    n_final;
    logic [8:0]  r_best,     n_best;
    logic [23:0] r_window,   n_window;
    logic [2:0]  r_count,    n_count;
    t_ip_state   r_ip,       n_ip;
    logic        r_overflow, n_overflow;
    logic        r_ended,    n_ended;

    logic        r_out_valid, n_out_valid;
    t_result     r_out,       n_out;
    logic        r_hold_valid, n_hold_valid;
    t_result     r_hold,      n_hold;

    t_ip_state   ip_step;
    logic        ip_ok;
    logic        accept;
    logic        take;
    logic        res_fire;
    logic        out_take;
    logic [8:0]  lim;
    logic [8:0]  start_w;
    logic [8:0]  len_w;
    t_result     res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUT_LIMIT) ? {23'd0, r_out_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit <= OUT_LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_OUT_LIMIT) begin
            r_out_limit <= pwdata[8:0];
        end
    end

    mde_ip_parse u_ip (
        .i_state (r_ip),
        .i_ch    (i_req.ch),
        .o_state (ip_step),
        .o_valid (ip_ok)
    );

    assign i_req.ready = !r_hold_valid;
    assign accept      = i_req.valid && i_req.ready;
    assign res_fire    = accept && i_req.last;
    assign out_take    = r_out_valid && o_res.ready;

    // Per-byte state after this byte, before the end-of-name clear.
    always_comb begin
        n_pos      = r_pos;
        n_final    = r_final;
        n_best     = r_best;
        n_window   = r_window;
        n_count    = r_count;
        n_ip       = r_ip;
        n_overflow = r_overflow;
        n_ended    = r_ended;
        take       = 1'b0;
        if (accept && !r_ended) begin
            if (i_req.ch == 8'd0) begin
                n_ended = 1'b1;
            end else if (r_pos >= 8'(MAX_LEN)) begin
                n_overflow = 1'b1;
            end else begin
                take = 1'b1;
            end
        end
        if (take) begin
            n_ip  = ip_step;
            n_pos = r_pos + 8'd1;
            if (i_req.ch == CH_DOT) begin
                // A dot only counts once the label after it is known not ignored.
                if (r_final[8] && r_final[7:0] != 8'd0 &&
                    !label_ignored(r_window, r_count)) begin
                    n_best = r_final;
                end
                n_final  = {1'b1, r_pos};
                n_window = '0;
                n_count  = '0;
            end else begin
                n_window = {r_window[15:0], i_req.ch};
                if (r_count < 3'd4) n_count = r_count + 3'd1;
            end
        end
    end

    // Range check of the held parser state, for a last byte that is dropped.
    function automatic logic ip_valid_hold();
        logic [32:0] pmax;
        case (r_ip.parts)
            2'd0:    pmax = 33'hFFFF_FFFF;
            2'd1:    pmax = 33'h00FF_FFFF;
            2'd2:    pmax = 33'h0000_FFFF;
            default: pmax = 33'h0000_00FF;
        endcase
        return r_ip.value <= pmax;
    endfunction

    always_comb begin
        lim     = (r_out_limit == 9'd0) ? 9'd0 : r_out_limit - 9'd1;
        start_w = 9'd0;
        if (take ? ip_ok : (r_ip.phase != PH_START && r_ip.phase != PH_HEX0 &&
                            r_ip.phase != PH_FAIL && ip_valid_hold())) begin
            res.kind = KIND_IPV4;
        end else if (!n_final[8]) begin
            res.kind = KIND_NO_DOT;
        end else if (n_best[8]) begin
            res.kind = KIND_MAIN;
            start_w  = {1'b0, n_best[7:0]} + 9'd1;
        end else begin
            res.kind = KIND_IGNORED;
        end
        len_w         = {1'b0, n_pos} - start_w;
        if (len_w > lim) len_w = lim;
        res.start_res = start_w[7:0];
        res.length    = len_w[7:0];
        res.too_long  = n_overflow;
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        if (r_hold_valid) begin
            if (out_take) begin
                n_out        = r_hold;
                n_hold_valid = 1'b0;
            end
        end else if (res_fire) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_hold       = res;
                n_hold_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_final      <= '0;
            r_best       <= '0;
            r_window     <= '0;
            r_count      <= '0;
            r_ip         <= '{phase: PH_START, parts: 2'd0, value: 33'd0};
            r_overflow   <= 1'b0;
            r_ended      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            if (res_fire) begin
                r_pos      <= '0;
                r_final    <= '0;
                r_best     <= '0;
                r_window   <= '0;
                r_count    <= '0;
                r_ip       <= '{phase: PH_START, parts: 2'd0, value: 33'd0};
                r_overflow <= 1'b0;
                r_ended    <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_final    <= n_final;
                r_best     <= n_best;
                r_window   <= n_window;
                r_count    <= n_count;
                r_ip       <= n_ip;
                r_overflow <= n_overflow;
                r_ended    <= n_ended;
            end
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.start_res = r_out.start_res;
    assign o_res.length    = r_out.length;
    assign o_res.kind      = r_out.kind;
    assign o_res.too_long  = r_out.too_long;

endmodule

`default_nettype wire
